// ===== rtl/sarp_pkg.sv =====
// shared types and constants for the stepper acceleration ramp positioner
`timescale 1ns / 1ps
package sarp_pkg;

  localparam int unsigned AccelW     = 16;
  localparam int unsigned PeriodW    = 8;
  localparam int unsigned StepLimitW = 15;
  localparam int unsigned PosW       = 16;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;
  localparam int unsigned InDataW    = 16;
  localparam int unsigned OutDataW   = 24;

  localparam logic [AccelW-1:0]     AccelPeriodRst = AccelW'(64);
  localparam logic [PeriodW-1:0]    MinPeriodRst   = PeriodW'(5);
  localparam logic [StepLimitW-1:0] StepLimitRst   = StepLimitW'(20000);
  localparam logic                  HomePolRst     = 1'b1;
  localparam logic [PeriodW-1:0]    PeriodSlowest  = PeriodW'(255);

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ACCEL_PERIOD  = 2'd0,
    CFG_MIN_PERIOD    = 2'd1,
    CFG_STEP_LIMIT    = 2'd2,
    CFG_HOME_POLARITY = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [AccelW-1:0]     accel_period;
    logic [PeriodW-1:0]    min_period;
    logic [StepLimitW-1:0] step_limit;
    logic                  home_polarity;
  } cfg_t;

  typedef struct packed {
    logic                   at_target;
    logic signed [PosW-1:0] position;
    logic                   direction_level;
    logic                   step_level;
  } result_t;

endpackage

// ===== rtl/sarp_motion.sv =====
// ramp, period counter and position state, updated once per accepted tick
`timescale 1ns / 1ps
module sarp_motion (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  sarp_pkg::cfg_t                 cfg_i,
  input  logic                           tick_i,
  input  logic signed [sarp_pkg::PosW-1:0] target_i,
  output sarp_pkg::result_t              result_o
);
  import sarp_pkg::*;

  logic [PeriodW-1:0]   step_period_q, step_period_d;
  logic [PeriodW-1:0]   period_cnt_q, period_cnt_d;
  logic [AccelW-1:0]    ramp_cnt_q, ramp_cnt_d;
  logic signed [PosW-1:0] pos_q, pos_d;
  logic                 step_pin_q, step_pin_d;
  logic                 dir_pin_q, dir_pin_d;

  logic               fire_ramp, fire_step, at_tgt, move_up, do_move, below_max;
  logic [PeriodW-1:0] period_ramped;

  always_comb begin
    fire_ramp = ramp_cnt_q >= cfg_i.accel_period;
    ramp_cnt_d = fire_ramp ? '0 : ramp_cnt_q + AccelW'(1);
    period_ramped = (fire_ramp && (step_period_q > cfg_i.min_period))
                    ? step_period_q - PeriodW'(1) : step_period_q;
    at_tgt = pos_q == target_i;
    step_period_d = at_tgt ? PeriodSlowest : period_ramped;
    fire_step = period_cnt_q >= step_period_d;
    period_cnt_d = fire_step ? '0 : period_cnt_q + PeriodW'(1);
    do_move = fire_step && !at_tgt;
    move_up = pos_q < target_i;
    below_max = pos_q < $signed({1'b0, cfg_i.step_limit});
    dir_pin_d = dir_pin_q;
    step_pin_d = step_pin_q;
    pos_d = pos_q;
    if (do_move) begin
      dir_pin_d = move_up ? ~cfg_i.home_polarity : cfg_i.home_polarity;
      if (below_max) begin
        step_pin_d = ~step_pin_q;
      end
      pos_d = move_up ? pos_q + PosW'(1) : pos_q - PosW'(1);
    end
    result_o.step_level      = step_pin_d;
    result_o.direction_level = dir_pin_d;
    result_o.position        = pos_d;
    result_o.at_target       = pos_d == target_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_period_q <= PeriodSlowest;
      period_cnt_q  <= '0;
      ramp_cnt_q    <= '0;
      pos_q         <= '0;
      step_pin_q    <= 1'b0;
      dir_pin_q     <= 1'b1;
    end else if (tick_i) begin
      step_period_q <= step_period_d;
      period_cnt_q  <= period_cnt_d;
      ramp_cnt_q    <= ramp_cnt_d;
      pos_q         <= pos_d;
      step_pin_q    <= step_pin_d;
      dir_pin_q     <= dir_pin_d;
    end
  end

endmodule

// ===== rtl/stepper_accel_ramp_positioner.sv =====
// top level: stream handshake, config registers and result register
//
// channel   | dir | fields
// s_axis    | in  | tdata[15:0] target_position
// m_axis    | out | tdata[0] step_level, [1] direction_level, [17:2] position, [18] at_target
// cfg       | in  | cfg_we_i, cfg_idx_i, cfg_data_i
//
// one tick per cycle unless the master side stalls: an input register and a result register,
// motion state updated as a tick moves from the input register into the result register
// a request goes through the input register and then the result register
// reset clears state to a stopped motor at position zero, period 255
// a stalled result register holds the input register, which then holds the slave side
`timescale 1ns / 1ps
module stepper_accel_ramp_positioner (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [sarp_pkg::InDataW-1:0]      s_axis_tdata_i,  // [15:0] target_position
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [sarp_pkg::OutDataW-1:0]     m_axis_tdata_o,  // step, dir, position, at_target
  input  logic                              cfg_we_i,
  input  logic [sarp_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [sarp_pkg::CfgDataW-1:0]     cfg_data_i
);
  import sarp_pkg::*;

  cfg_t    cfg_q;
  logic    in_vld_q, out_vld_q, adv;
  logic signed [PosW-1:0] tgt_q;
  result_t res, res_q;

  assign adv             = !out_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_vld_q || adv;
  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {{(OutDataW - $bits(result_t)){1'b0}}, res_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.accel_period  <= AccelPeriodRst;
      cfg_q.min_period    <= MinPeriodRst;
      cfg_q.step_limit    <= StepLimitRst;
      cfg_q.home_polarity <= HomePolRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ACCEL_PERIOD:  cfg_q.accel_period  <= cfg_data_i[AccelW-1:0];
        CFG_MIN_PERIOD:    cfg_q.min_period    <= cfg_data_i[PeriodW-1:0];
        CFG_STEP_LIMIT:    cfg_q.step_limit    <= cfg_data_i[StepLimitW-1:0];
        CFG_HOME_POLARITY: cfg_q.home_polarity <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (s_axis_tready_o) begin
        in_vld_q <= s_axis_tvalid_i;
      end
      if (adv) begin
        out_vld_q <= in_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      tgt_q <= $signed(s_axis_tdata_i[PosW-1:0]);
    end
    if (adv && in_vld_q) begin
      res_q <= res;
    end
  end

  sarp_motion u_motion (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .tick_i   (adv && in_vld_q),
    .target_i (tgt_q),
    .result_o (res)
  );

endmodule
